// File: hw/rtl/mbm_pkg.sv
// Shared types, codes and constants for the Modbus RTU master transaction sequencer.
// Used by every module under hw/rtl; depends on nothing.

package mbm_pkg;

   // transaction kinds on the request side (carried in tuser)
   localparam logic [1:0] OP_REQUEST = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_RXBYTE  = 2'd2;
   localparam logic [1:0] OP_VERDICT = 2'd3;

   // result event kinds
   localparam logic [2:0] EV_ARMED     = 3'd0;
   localparam logic [2:0] EV_TURN_DONE = 3'd1;
   localparam logic [2:0] EV_RESPONSE  = 3'd2;
   localparam logic [2:0] EV_DONE      = 3'd3;
   localparam logic [2:0] EV_ERROR     = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_TIMEOUT = 2'd1;
   localparam logic [1:0] ERR_CRC     = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_TURNAROUND    = 2'd0;
   localparam logic [1:0] REG_READ_TIMEOUT  = 2'd1;
   localparam logic [1:0] REG_WRITE_TIMEOUT = 2'd2;

   localparam logic [15:0] TURNAROUND_RESET    = 16'd100;
   localparam logic [15:0] READ_TIMEOUT_RESET  = 16'd1000;
   localparam logic [15:0] WRITE_TIMEOUT_RESET = 16'd1000;

   // Modbus function codes that select the write timeout
   localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
   localparam logic [7:0] FUNC_MASK       = 8'h7F;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int MAX_FRAME_BYTES = 256;

   typedef struct packed {
      logic [15:0] turnaround_ticks;
      logic [15:0] read_timeout_ticks;
      logic [15:0] write_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] slave_id;
      logic [7:0] function_code;
      logic [7:0] rx_byte;
      logic       frame_end;
      logic       accept;
   } item_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [1:0] error_code;
      logic [7:0] resp_slave_id;
      logic [6:0] resp_function;
      logic [7:0] resp_exception;
      logic [8:0] frame_length;
   } result_type;

endpackage

// File: hw/rtl/mbm_crc16.sv
// One-byte update of the Modbus CRC16 (reflected polynomial 0xA001).
// Depends on mbm_pkg.

module mbm_crc16 (
   input  logic [15:0] crc,
   input  logic [7:0]  data,
   output logic [15:0] crc_next
);

   logic [15:0] work;

   always_comb begin
      work = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         work = work[0] ? ((work >> 1) ^ mbm_pkg::CRC_POLY) : (work >> 1);
      end
      crc_next = work;
   end

endmodule

// File: hw/rtl/mbm_csr.sv
// Configuration registers: turnaround and timeout tick counts.
// Depends on mbm_pkg.

module mbm_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata,
   output mbm_pkg::cfg_type cfg
);

   mbm_pkg::cfg_type cfg_ff;
   mbm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            mbm_pkg::REG_TURNAROUND:    cfg_in.turnaround_ticks    = csr_wdata;
            mbm_pkg::REG_READ_TIMEOUT:  cfg_in.read_timeout_ticks  = csr_wdata;
            mbm_pkg::REG_WRITE_TIMEOUT: cfg_in.write_timeout_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.turnaround_ticks    <= mbm_pkg::TURNAROUND_RESET;
         cfg_ff.read_timeout_ticks  <= mbm_pkg::READ_TIMEOUT_RESET;
         cfg_ff.write_timeout_ticks <= mbm_pkg::WRITE_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/mbm_seq.sv
// Transaction sequencer: phase, tick timer, running CRC, byte count and head bytes.
// Processes one registered transaction per enabled cycle. Depends on mbm_pkg, mbm_crc16.

module mbm_seq #(
   parameter int MAX_FRAME_BYTES = mbm_pkg::MAX_FRAME_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  mbm_pkg::item_type   item,
   input  mbm_pkg::cfg_type    cfg,
   output logic                res_valid,
   output mbm_pkg::result_type res
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_TURN    = 2'd1;
   localparam logic [1:0] PH_WAIT    = 2'd2;
   localparam logic [1:0] PH_VERDICT = 2'd3;

   localparam logic [8:0] MaxCount = 9'(MAX_FRAME_BYTES);

   logic [1:0]  phase_ff,  phase_in;
   logic [15:0] timer_ff,  timer_in;
   logic [15:0] crc_ff,    crc_in;
   logic [8:0]  count_ff,  count_in;
   logic [7:0]  head0_ff,  head0_in;
   logic [7:0]  head1_ff,  head1_in;
   logic [7:0]  head2_ff,  head2_in;
   logic [7:0]  target_ff, target_in;

   logic [15:0] crc_next;
   logic [7:0]  h0_new, h1_new, h2_new;
   logic [8:0]  count_new;
   logic        is_write;

   mbm_crc16 u_crc (
      .crc      (crc_ff),
      .data     (item.rx_byte),
      .crc_next (crc_next)
   );

   always_comb begin
      h0_new    = (count_ff == 9'd0) ? item.rx_byte : head0_ff;
      h1_new    = (count_ff == 9'd1) ? item.rx_byte : head1_ff;
      h2_new    = (count_ff == 9'd2) ? item.rx_byte : head2_ff;
      count_new = (count_ff < MaxCount) ? count_ff + 9'd1 : count_ff;
      is_write  = (item.function_code == mbm_pkg::FC_WRITE_SINGLE)
               || (item.function_code == mbm_pkg::FC_WRITE_MULTI);
   end

   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      crc_in    = crc_ff;
      count_in  = count_ff;
      head0_in  = head0_ff;
      head1_in  = head1_ff;
      head2_in  = head2_ff;
      target_in = target_ff;
      res_valid = 1'b0;
      res       = '0;

      if (enable) begin
         case (item.opcode)
            mbm_pkg::OP_REQUEST: begin
               if (phase_ff == PH_IDLE) begin
                  target_in = item.slave_id;
                  crc_in    = mbm_pkg::CRC_INIT;
                  count_in  = '0;
                  head0_in  = '0;
                  head1_in  = '0;
                  head2_in  = '0;
                  if (item.slave_id == 8'd0) begin
                     timer_in = cfg.turnaround_ticks;
                     phase_in = PH_TURN;
                  end else begin
                     timer_in = is_write ? cfg.write_timeout_ticks : cfg.read_timeout_ticks;
                     phase_in = PH_WAIT;
                  end
                  res_valid      = 1'b1;
                  res.event_kind = mbm_pkg::EV_ARMED;
               end
            end

            mbm_pkg::OP_TICK: begin
               if (phase_ff == PH_TURN || phase_ff == PH_WAIT) begin
                  if (timer_ff > 16'd1) begin
                     timer_in = timer_ff - 16'd1;
                  end else begin
                     timer_in  = '0;
                     phase_in  = PH_IDLE;
                     res_valid = 1'b1;
                     if (phase_ff == PH_TURN) begin
                        res.event_kind = mbm_pkg::EV_TURN_DONE;
                     end else begin
                        res.event_kind     = mbm_pkg::EV_ERROR;
                        res.error_code     = mbm_pkg::ERR_TIMEOUT;
                        res.resp_slave_id  = head0_ff;
                        res.resp_function  = 7'(head1_ff & mbm_pkg::FUNC_MASK);
                        res.resp_exception = head2_ff;
                        res.frame_length   = count_ff;
                     end
                  end
               end
            end

            mbm_pkg::OP_RXBYTE: begin
               if (phase_ff == PH_WAIT) begin
                  crc_in   = crc_next;
                  head0_in = h0_new;
                  head1_in = h1_new;
                  head2_in = h2_new;
                  count_in = count_new;
                  if (item.frame_end) begin
                     if (h0_new != target_ff) begin
                        // foreign frame: restart capture, keep the timer running
                        crc_in   = mbm_pkg::CRC_INIT;
                        count_in = '0;
                        head0_in = '0;
                        head1_in = '0;
                        head2_in = '0;
                     end else begin
                        timer_in           = '0;
                        res_valid          = 1'b1;
                        res.resp_slave_id  = h0_new;
                        res.resp_function  = 7'(h1_new & mbm_pkg::FUNC_MASK);
                        res.resp_exception = h2_new;
                        res.frame_length   = count_new;
                        if (crc_next != 16'd0) begin
                           phase_in       = PH_IDLE;
                           res.event_kind = mbm_pkg::EV_ERROR;
                           res.error_code = mbm_pkg::ERR_CRC;
                        end else if (h1_new[7]) begin
                           phase_in       = PH_IDLE;
                           res.event_kind = mbm_pkg::EV_ERROR;
                           res.error_code = mbm_pkg::ERR_NONE;
                        end else begin
                           phase_in       = PH_VERDICT;
                           res.event_kind = mbm_pkg::EV_RESPONSE;
                        end
                     end
                  end
               end
            end

            mbm_pkg::OP_VERDICT: begin
               if (phase_ff == PH_VERDICT) begin
                  phase_in           = PH_IDLE;
                  res_valid          = 1'b1;
                  res.event_kind     = item.accept ? mbm_pkg::EV_DONE : mbm_pkg::EV_ERROR;
                  res.error_code     = mbm_pkg::ERR_NONE;
                  res.resp_slave_id  = head0_ff;
                  res.resp_function  = 7'(head1_ff & mbm_pkg::FUNC_MASK);
                  res.resp_exception = head2_ff;
                  res.frame_length   = count_ff;
               end
            end

            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         timer_ff  <= '0;
         crc_ff    <= mbm_pkg::CRC_INIT;
         count_ff  <= '0;
         head0_ff  <= '0;
         head1_ff  <= '0;
         head2_ff  <= '0;
         target_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         head0_ff  <= head0_in;
         head1_ff  <= head1_in;
         head2_ff  <= head2_in;
         target_ff <= target_in;
      end
   end

endmodule

// File: hw/rtl/modbus_master_transaction_fsm.sv
// Modbus RTU master transaction sequencer, stream top level.
// Each transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle;
// the input register drains whenever the result register is empty or being taken.
// Reset is synchronous and active high: idle phase, CRC 0xFFFF, default tick counts.
// Depends on mbm_pkg, mbm_csr, mbm_seq.

module modbus_master_transaction_fsm #(
   parameter int MAX_FRAME_BYTES = mbm_pkg::MAX_FRAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // slave_id[7:0], function_code[15:8], rx_byte[23:16], accept[24]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   input  logic        req_tlast,   // frame_end

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // error_code[1:0], resp_slave_id[9:2], resp_function[16:10],
                                    // resp_exception[24:17], frame_length[33:25]
   output logic [2:0]  rsp_tuser,   // event_kind[2:0]

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   mbm_pkg::cfg_type    cfg;
   mbm_pkg::item_type   item_ff, item_in;
   logic                in_valid_ff, in_valid_in;
   mbm_pkg::result_type rsp_ff, rsp_in;
   mbm_pkg::result_type res;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                res_valid;
   logic                advance;

   mbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbm_seq #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .item      (item_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // process the held transaction when the result slot is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in           = req_tvalid;
         item_in.opcode        = req_tuser;
         item_in.slave_id      = req_tdata[7:0];
         item_in.function_code = req_tdata[15:8];
         item_in.rx_byte       = req_tdata[23:16];
         item_in.accept        = req_tdata[24];
         item_in.frame_end     = req_tlast;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         rsp_valid_in = res_valid;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.event_kind;
   assign rsp_tdata  = {6'd0, rsp_ff.frame_length, rsp_ff.resp_exception,
                        rsp_ff.resp_function, rsp_ff.resp_slave_id, rsp_ff.error_code};

endmodule
